// ===== rtl/bbpg_pkg.sv =====
package bbpg_pkg;

    localparam int TICK_W   = 16;
    localparam int COUNT_W  = 8;
    localparam int BEEPS_W  = 4;
    localparam int CFG_IDX_W = 2;

    // Command codes.
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_TICKS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_TICKS    = 2'd2;

    // Register values after reset.
    localparam logic [TICK_W-1:0] RST_TOGGLE_TICKS = 16'd100;
    localparam logic [TICK_W-1:0] RST_ON_TICKS     = 16'd200;
    localparam logic [TICK_W-1:0] RST_OFF_TICKS    = 16'd500;

    typedef struct packed {
        logic [TICK_W-1:0] toggle_ticks;
        logic [TICK_W-1:0] on_ticks;
        logic [TICK_W-1:0] off_ticks;
    } t_cfg;

    typedef struct packed {
        logic               cmd;
        logic [COUNT_W-1:0] beep_count;
    } t_item;

endpackage

// ===== rtl/bbpg_in_if.sv =====
interface bbpg_in_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [bbpg_pkg::COUNT_W-1:0]  beep_count;

    modport source (output valid, output cmd, output beep_count, input ready);
    modport sink   (input valid, input cmd, input beep_count, output ready);
endinterface

// ===== rtl/bbpg_out_if.sv =====
interface bbpg_out_if;
    logic                          valid;
    logic                          ready;
    logic                          buzzer_on;
    logic                          active;
    logic [bbpg_pkg::BEEPS_W-1:0]  beeps_sounded;

    modport source (output valid, output buzzer_on, output active, output beeps_sounded,
                    input ready);
    modport sink   (input valid, input buzzer_on, input active, input beeps_sounded,
                    output ready);
endinterface

// ===== rtl/bbpg_cfg.sv =====
module bbpg_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr_en,
    input  logic [bbpg_pkg::CFG_IDX_W-1:0]    i_wr_idx,
    input  logic [bbpg_pkg::TICK_W-1:0]       i_wr_data,
    output bbpg_pkg::t_cfg                    o_cfg
);

    bbpg_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.toggle_ticks <= bbpg_pkg::RST_TOGGLE_TICKS;
            r_cfg.on_ticks     <= bbpg_pkg::RST_ON_TICKS;
            r_cfg.off_ticks    <= bbpg_pkg::RST_OFF_TICKS;
        end else if (i_wr_en) begin
            unique case (i_wr_idx)
                bbpg_pkg::CFG_TOGGLE_TICKS: r_cfg.toggle_ticks <= i_wr_data;
                bbpg_pkg::CFG_ON_TICKS:     r_cfg.on_ticks     <= i_wr_data;
                bbpg_pkg::CFG_OFF_TICKS:    r_cfg.off_ticks    <= i_wr_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/bbpg_in_stage.sv =====
module bbpg_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    bbpg_in_if.sink         i_req,
    input  logic            i_next_ready,
    output logic            o_valid,
    output bbpg_pkg::t_item o_item
);

    logic            r_valid;
    bbpg_pkg::t_item r_item;
    logic            w_ready;

    // The register frees up whenever the core takes its request.
    assign w_ready     = !r_valid || i_next_ready;
    assign i_req.ready = w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_req.valid) begin
            r_item.cmd        <= i_req.cmd;
            r_item.beep_count <= i_req.beep_count;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/bbpg_core.sv =====
module bbpg_core #(
    parameter int MAX_BEEPS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bbpg_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    input  bbpg_pkg::t_item i_item,
    output logic            o_ready,
    bbpg_out_if.source      o_rsp
);

    localparam logic [bbpg_pkg::BEEPS_W-1:0] MaxBeeps   = bbpg_pkg::BEEPS_W'(MAX_BEEPS);
    localparam logic [bbpg_pkg::COUNT_W-1:0] MaxBeepsCn = bbpg_pkg::COUNT_W'(MAX_BEEPS);

    logic [bbpg_pkg::TICK_W-1:0]  r_tick,  n_tick;
    logic [bbpg_pkg::BEEPS_W-1:0] r_total, n_total;
    logic [bbpg_pkg::BEEPS_W-1:0] r_done,  n_done;
    logic                         r_level, n_level;
    logic                         r_cont,  n_cont;

    logic                         r_out_valid;
    logic                         r_out_level;
    logic                         r_out_active;
    logic [bbpg_pkg::BEEPS_W-1:0] r_out_done;

    logic [bbpg_pkg::TICK_W-1:0]  w_tick_inc;
    logic [bbpg_pkg::BEEPS_W-1:0] w_done_inc;
    logic                         w_fire;

    assign o_ready = !r_out_valid || o_rsp.ready;
    assign w_fire  = i_valid && o_ready;

    assign w_tick_inc = r_tick + 1'b1;
    assign w_done_inc = r_done + 1'b1;

    always_comb begin
        n_tick  = r_tick;
        n_total = r_total;
        n_done  = r_done;
        n_level = r_level;
        n_cont  = r_cont;
        case (i_item.cmd)
            bbpg_pkg::CMD_START: begin
                n_total = (i_item.beep_count > MaxBeepsCn) ? MaxBeeps
                        : i_item.beep_count[bbpg_pkg::BEEPS_W-1:0];
                n_done  = '0;
                n_tick  = '0;
                n_level = 1'b0;
                n_cont  = (i_item.beep_count == '0);
            end
            default: begin
                n_tick = w_tick_inc;
                if (r_cont) begin
                    if (w_tick_inc >= i_cfg.toggle_ticks) begin
                        n_tick  = '0;
                        n_level = !r_level;
                    end
                end else if (r_total != '0) begin
                    if (r_level && (w_tick_inc >= i_cfg.on_ticks)) begin
                        n_level = 1'b0;
                        n_tick  = '0;
                        n_done  = w_done_inc;
                        if (w_done_inc >= r_total) begin
                            n_total = '0;
                        end
                    end else if (!r_level && (w_tick_inc >= i_cfg.off_ticks)) begin
                        n_level = 1'b1;
                        n_tick  = '0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick      <= '0;
            r_total     <= '0;
            r_done      <= '0;
            r_level     <= 1'b0;
            r_cont      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_tick  <= n_tick;
                r_total <= n_total;
                r_done  <= n_done;
                r_level <= n_level;
                r_cont  <= n_cont;
            end
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_level  <= n_level;
            r_out_active <= n_cont || (n_total != '0);
            r_out_done   <= n_done;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.buzzer_on     = r_out_level;
    assign o_rsp.active        = r_out_active;
    assign o_rsp.beeps_sounded = r_out_done;

endmodule

// ===== rtl/buzzer_beep_pattern_generator.sv =====
// Buzzer beep pattern generator. Each request is either a timer tick or a start
// command; every request yields one result with the buzzer level, the active flag
// and the number of beeps completed. A start with a count of zero runs the
// continuous toggle mode, otherwise the count (clamped to MAX_BEEPS) sets how many
// off/on beeps are played. The block takes one request per clock cycle while the result
// side is ready, and passes each through the input register and then the core, where
// the state update feeds the result register. The user writes the tick, on and off
// times through the configuration port only while idle; the block does not enforce it.
module buzzer_beep_pattern_generator #(
    parameter int MAX_BEEPS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [bbpg_pkg::CFG_IDX_W-1:0] i_cfg_wr_idx,
    input  logic [bbpg_pkg::TICK_W-1:0]    i_cfg_wr_data,
    bbpg_in_if.sink                        i_req,
    bbpg_out_if.source                     o_rsp
);

    bbpg_pkg::t_cfg  w_cfg;
    bbpg_pkg::t_item w_item;
    logic            w_item_valid;
    logic            w_core_ready;

    bbpg_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_cfg_wr_en),
        .i_wr_idx  (i_cfg_wr_idx),
        .i_wr_data (i_cfg_wr_data),
        .o_cfg     (w_cfg)
    );

    bbpg_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_next_ready (w_core_ready),
        .o_valid      (w_item_valid),
        .o_item       (w_item)
    );

    bbpg_core #(
        .MAX_BEEPS (MAX_BEEPS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_item_valid),
        .i_item  (w_item),
        .o_ready (w_core_ready),
        .o_rsp   (o_rsp)
    );

endmodule

// ===== test/tb_buzzer_beep_pattern_generator.sv =====
module tb_buzzer_beep_pattern_generator;

    localparam int MAX_BEEPS   = 8;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 8;

    // No register lives at this index; writes to it must leave the block unchanged.
    localparam logic [bbpg_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef struct packed {
        logic                         buzzer_on;
        logic                         active;
        logic [bbpg_pkg::BEEPS_W-1:0] beeps_sounded;
    } t_beep_status;

    // Tracks the pattern state of the block and holds the statuses still owed by it.
    class beep_tracker;
        bbpg_pkg::t_cfg               cfg;
        logic [bbpg_pkg::TICK_W-1:0]  tick_count;
        logic [bbpg_pkg::BEEPS_W-1:0] beeps_total;
        logic [bbpg_pkg::BEEPS_W-1:0] beeps_done;
        logic                         level;
        logic                         continuous;
        t_beep_status                 owed_status[$];
        int                           n_starts;
        int                           n_ticks;
        int                           n_checked;
        int                           n_errors;

        function new();
            cfg.toggle_ticks = bbpg_pkg::RST_TOGGLE_TICKS;
            cfg.on_ticks     = bbpg_pkg::RST_ON_TICKS;
            cfg.off_ticks    = bbpg_pkg::RST_OFF_TICKS;
            tick_count  = '0;
            beeps_total = '0;
            beeps_done  = '0;
            level       = 1'b0;
            continuous  = 1'b0;
            n_starts  = 0;
            n_ticks   = 0;
            n_checked = 0;
            n_errors  = 0;
        endfunction

        function void write_reg(logic [bbpg_pkg::CFG_IDX_W-1:0] idx,
                                logic [bbpg_pkg::TICK_W-1:0] data);
            case (idx)
                bbpg_pkg::CFG_TOGGLE_TICKS: cfg.toggle_ticks = data;
                bbpg_pkg::CFG_ON_TICKS:     cfg.on_ticks = data;
                bbpg_pkg::CFG_OFF_TICKS:    cfg.off_ticks = data;
                default: ;
            endcase
        endfunction

        function void take_request(logic cmd, logic [bbpg_pkg::COUNT_W-1:0] count);
            t_beep_status status;
            if (cmd == bbpg_pkg::CMD_START) begin
                n_starts++;
                beeps_total = (count > MAX_BEEPS) ? bbpg_pkg::BEEPS_W'(MAX_BEEPS)
                                                  : count[bbpg_pkg::BEEPS_W-1:0];
                beeps_done  = '0;
                tick_count  = '0;
                level       = 1'b0;
                continuous  = (count == '0);
            end else begin
                n_ticks++;
                tick_count = tick_count + 1'b1;
                if (continuous) begin
                    if (tick_count >= cfg.toggle_ticks) begin
                        tick_count = '0;
                        level = !level;
                    end
                end else if (beeps_total != '0) begin
                    if (level && tick_count >= cfg.on_ticks) begin
                        level = 1'b0;
                        tick_count = '0;
                        beeps_done = beeps_done + 1'b1;
                        if (beeps_done >= beeps_total)
                            beeps_total = '0;
                    end else if (!level && tick_count >= cfg.off_ticks) begin
                        level = 1'b1;
                        tick_count = '0;
                    end
                end
            end
            status.buzzer_on     = level;
            status.active        = continuous || (beeps_total != '0);
            status.beeps_sounded = beeps_done;
            owed_status.push_back(status);
        endfunction

        function void check_result(t_beep_status got);
            t_beep_status want;
            n_checked++;
            if (owed_status.size() == 0) begin
                $error("result with no request outstanding: buzzer_on=%0b active=%0b beeps=%0d",
                       got.buzzer_on, got.active, got.beeps_sounded);
                n_errors++;
                return;
            end
            want = owed_status.pop_front();
            if (got.buzzer_on !== want.buzzer_on) begin
                $error("buzzer_on: expected %0b, got %0b", want.buzzer_on, got.buzzer_on);
                n_errors++;
            end
            if (got.active !== want.active) begin
                $error("active: expected %0b, got %0b", want.active, got.active);
                n_errors++;
            end
            if (got.beeps_sounded !== want.beeps_sounded) begin
                $error("beeps_sounded: expected %0d, got %0d",
                       want.beeps_sounded, got.beeps_sounded);
                n_errors++;
            end
        endfunction

        function int outstanding();
            return owed_status.size();
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_wr_en;
    logic [bbpg_pkg::CFG_IDX_W-1:0] i_cfg_wr_idx;
    logic [bbpg_pkg::TICK_W-1:0]    i_cfg_wr_data;

    bbpg_in_if  req_if();
    bbpg_out_if rsp_if();

    beep_tracker tracker = new();
    int          cycle_count = 0;
    int          n_settings = 0;
    bit          steady = 1'b0;

    buzzer_beep_pattern_generator #(
        .MAX_BEEPS(MAX_BEEPS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_wr_idx(i_cfg_wr_idx),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_req(req_if),
        .o_rsp(rsp_if)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("buzzer_beep_pattern_generator regression: fail");
            $finish;
        end
    end

    // Both handshakes are sampled here, with the values that held before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready)
                tracker.check_result({rsp_if.buzzer_on, rsp_if.active, rsp_if.beeps_sounded});
            if (req_if.valid && req_if.ready)
                tracker.take_request(req_if.cmd, req_if.beep_count);
        end
    end

    initial begin
        int stall;
        rsp_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = steady ? 0 : $urandom_range(7);
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
        end
    end

    task automatic send_request(input logic cmd, input logic [bbpg_pkg::COUNT_W-1:0] count);
        int gap;
        gap = steady ? 0 : $urandom_range(7);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.cmd        <= cmd;
        req_if.beep_count <= count;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic wait_idle();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [bbpg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bbpg_pkg::TICK_W-1:0] data);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_idx  <= idx;
        i_cfg_wr_data <= data;
        @(posedge i_clk);
        tracker.write_reg(idx, data);
    endtask

    task automatic program_regs(input logic [bbpg_pkg::TICK_W-1:0] toggle,
                                input logic [bbpg_pkg::TICK_W-1:0] on,
                                input logic [bbpg_pkg::TICK_W-1:0] off,
                                input bit poke_unused);
        wait_idle();
        write_reg(bbpg_pkg::CFG_TOGGLE_TICKS, toggle);
        write_reg(bbpg_pkg::CFG_ON_TICKS, on);
        write_reg(bbpg_pkg::CFG_OFF_TICKS, off);
        if (poke_unused)
            write_reg(CFG_UNUSED_IDX, '1);
        i_cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    // Mostly a start followed by enough ticks to play part or all of the pattern;
    // the rest is stray ticks and back-to-back starts that cut a pattern short.
    task automatic play_random(input int target);
        int first;
        int kind;
        int len;
        int beat;
        int beeps;
        logic [bbpg_pkg::COUNT_W-1:0] count;
        first = tracker.n_starts + tracker.n_ticks;
        while (tracker.n_starts + tracker.n_ticks - first < target) begin
            kind = $urandom_range(9);
            if (kind < 8) begin
                case ($urandom_range(5))
                    0: count = '0;
                    1: count = bbpg_pkg::COUNT_W'($urandom_range(255, MAX_BEEPS + 1));
                    default: count = bbpg_pkg::COUNT_W'($urandom_range(MAX_BEEPS, 1));
                endcase
                send_request(bbpg_pkg::CMD_START, count);
                if (count == '0) begin
                    len = $urandom_range(40, 1);
                end else begin
                    beeps = (count > MAX_BEEPS) ? MAX_BEEPS : int'(count);
                    beat = int'(tracker.cfg.on_ticks) + int'(tracker.cfg.off_ticks) + 2;
                    len = beeps * beat;
                    if (len > 150)
                        len = 150;
                    len = $urandom_range(1) ? len + $urandom_range(5) : $urandom_range(len, 1);
                end
                repeat (len) send_request(bbpg_pkg::CMD_TICK, bbpg_pkg::COUNT_W'($urandom));
            end else if (kind == 8) begin
                repeat ($urandom_range(6, 1))
                    send_request(bbpg_pkg::CMD_TICK, bbpg_pkg::COUNT_W'($urandom));
            end else begin
                send_request(bbpg_pkg::CMD_START, bbpg_pkg::COUNT_W'($urandom));
            end
            if ($urandom_range(15) == 0)
                wait_idle();
            steady = ($urandom_range(3) == 0);
        end
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        i_cfg_wr_en       <= 1'b0;
        i_cfg_wr_idx      <= bbpg_pkg::CFG_TOGGLE_TICKS;
        i_cfg_wr_data     <= '0;
        req_if.valid      <= 1'b0;
        req_if.cmd        <= bbpg_pkg::CMD_TICK;
        req_if.beep_count <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values: the long off time keeps the buzzer silent.
        send_request(bbpg_pkg::CMD_START, 8'd3);
        send_request(bbpg_pkg::CMD_TICK, 8'd0);
        send_request(bbpg_pkg::CMD_TICK, 8'd0);

        // Short times, plus a write to the unused index that must change nothing.
        program_regs(16'd2, 16'd1, 16'd3, 1'b1);
        send_request(bbpg_pkg::CMD_START, 8'd0);
        repeat (3) send_request(bbpg_pkg::CMD_TICK, 8'd0);
        send_request(bbpg_pkg::CMD_START, 8'hFF);
        send_request(bbpg_pkg::CMD_TICK, 8'hFF);
        send_request(bbpg_pkg::CMD_START, 8'd1);
        repeat (4) send_request(bbpg_pkg::CMD_TICK, 8'd0);
        send_request(bbpg_pkg::CMD_TICK, 8'h5A);

        // With all times at zero the level flips on every tick.
        program_regs(16'd0, 16'd0, 16'd0, 1'b0);
        send_request(bbpg_pkg::CMD_START, 8'd0);
        repeat (2) send_request(bbpg_pkg::CMD_TICK, 8'd0);
        send_request(bbpg_pkg::CMD_START, 8'd2);
        repeat (4) send_request(bbpg_pkg::CMD_TICK, 8'd0);

        // Largest times, run back to back: the level holds through a short burst of ticks.
        program_regs('1, '1, '1, 1'b0);
        steady = 1'b1;
        send_request(bbpg_pkg::CMD_START, 8'd0);
        repeat (20) send_request(bbpg_pkg::CMD_TICK, 8'd0);
        send_request(bbpg_pkg::CMD_START, 8'd1);
        repeat (20) send_request(bbpg_pkg::CMD_TICK, 8'd0);
        steady = 1'b0;

        program_regs(16'd1, 16'd1, 16'd1, 1'b0);
        play_random(60);
        program_regs('1, 16'd1, 16'd2, 1'b0);
        play_random(50);
        program_regs(16'd4, 16'd0, 16'd2, 1'b0);
        play_random(50);
        repeat (5) begin
            program_regs(bbpg_pkg::TICK_W'($urandom_range(8, 1)),
                         bbpg_pkg::TICK_W'($urandom_range(8, 1)),
                         bbpg_pkg::TICK_W'($urandom_range(8, 1)), 1'b0);
            play_random(55);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d starts and %0d ticks over %0d register settings.",
                 tracker.n_starts, tracker.n_ticks, n_settings);
        $display("Compared %0d results; %0d field mismatches found.",
                 tracker.n_checked, tracker.n_errors);
        if (tracker.n_errors == 0 && tracker.outstanding() == 0) begin
            $display("buzzer_beep_pattern_generator regression: pass");
        end else begin
            $display("buzzer_beep_pattern_generator regression: fail");
        end
        $finish;
    end

endmodule
